>>> src/per_source_connection_rate_limiter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the per-source connection rate limiter
// Shared helpers for the concurrent checks in the RTL modules.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_CONNECTION_RATE_LIMITER_MACROS_SVH
`define PER_SOURCE_CONNECTION_RATE_LIMITER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PSRL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate limiter assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PSRL_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate limiter assertion failed");

`endif

>>> src/psrl_pkg.sv
// ----------------------------------------------------------------------------
// psrl_pkg
// Types and constants shared by the connection rate limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package psrl_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);

   localparam int ADDR_W   = 32;
   localparam int TIME_W   = 48;
   localparam int COUNT_W  = 16;
   localparam int WINDOW_W = 16;
   localparam int MAX_W    = 16;
   localparam int BLOCK_W  = 24;

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_PER_WINDOW = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LENGTH = 2'd2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
   localparam logic [MAX_W-1:0]    MAX_RESET    = 16'd10;
   localparam logic [BLOCK_W-1:0]  BLOCK_RESET  = 24'd10000;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef enum logic [2:0] {
      V_OK       = 3'd0,
      V_ZERO     = 3'd1,
      V_BLOCKED  = 3'd2,
      V_NEWBLOCK = 3'd3,
      V_FULL     = 3'd4
   } verdict_type;

   // What the lookup stage decided about a request.
   typedef enum logic [1:0] {
      KIND_ZERO   = 2'd0,
      KIND_HIT    = 2'd1,
      KIND_INSERT = 2'd2,
      KIND_FULL   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [TIME_W-1:0]  window_start;
      logic [TIME_W-1:0]  block_until;
      logic [COUNT_W-1:0] count;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] hit_idx;
      logic             free;
      logic [IDX_W-1:0] free_idx;
   } cam_result_type;

endpackage

`default_nettype wire

>>> src/per_source_connection_rate_limiter.sv
// ----------------------------------------------------------------------------
// per_source_connection_rate_limiter
// Per-source connection rate limiter with a fully associative address table.
// ----------------------------------------------------------------------------
// Usage:
// A connection request transaction on the req_ stream carries the IPv4 source
// address and the current millisecond time. Exactly one response transaction
// per request appears on the rsp_ stream, in request order, with the accept
// flag and a verdict code. The csr_ channel writes the window length, the
// per-window limit and the block length; it is always ready and should only
// be used while no requests are in flight.
// An accepted request reaches rsp_tvalid through a lookup stage (address
// compare over all table entries), a decision stage (record read from the
// table RAM, bypassed from the previous write) and the response register.
// One request is accepted every cycle as long as the receiver keeps taking
// responses; the rate is set by the combinational compare over the table
// and one RAM write per cycle.
// When the receiver stalls, the pipeline keeps accepting requests until all
// stages hold a transaction, then req_tready drops. Reset empties the table
// and the pipeline and restores the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_source_connection_rate_limiter_macros.svh"

module per_source_connection_rate_limiter (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Request stream.
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [31:0] source_address, [79:32] now_ms
   input  wire logic [psrl_pkg::REQ_DATA_W-1:0]      req_tdata,
   // Response stream.
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // [0] accepted, [3:1] verdict_code, [7:4] zero
   output logic      [psrl_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Configuration write channel.
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [psrl_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [psrl_pkg::CSR_DATA_W-1:0]      csr_data
);
   import psrl_pkg::*;

   // Configuration registers.
   logic [WINDOW_W-1:0] window_ff;
   logic [MAX_W-1:0]    max_ff;
   logic [BLOCK_W-1:0]  block_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         max_ff    <= MAX_RESET;
         block_ff  <= BLOCK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:  window_ff <= csr_data[WINDOW_W-1:0];
            CSR_MAX_PER_WINDOW: max_ff    <= csr_data[MAX_W-1:0];
            CSR_BLOCK_LENGTH:   block_ff  <= csr_data[BLOCK_W-1:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // Pipeline flow control: each stage moves when the one after it is empty
   // or moving in the same cycle.
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic out_free, move2, st2_free, move1, st1_free, take_req;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign move2      = s2_valid_ff && out_free;
   assign st2_free   = !s2_valid_ff || move2;
   assign move1      = s1_valid_ff && st2_free;
   assign st1_free   = !s1_valid_ff || move1;
   assign req_tready = st1_free;
   assign take_req   = req_tvalid && req_tready;

   // Lookup stage.
   logic [ADDR_W-1:0] s1_addr_ff;
   logic [TIME_W-1:0] s1_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (st1_free) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_addr_ff <= req_tdata[ADDR_W-1:0];
         s1_now_ff  <= req_tdata[ADDR_W +: TIME_W];
      end
   end

   cam_result_type cam_res;
   logic           s1_zero;
   logic           cam_insert;
   kind_type       s1_kind;
   logic [IDX_W-1:0]  s1_idx;
   logic [TIME_W:0]   block_sum;
   logic [TIME_W-1:0] s1_block_end;

   assign s1_zero    = (s1_addr_ff == '0);
   assign cam_insert = move1 && !s1_zero && !cam_res.hit && cam_res.free;

   psrl_cam u_cam (
      .clock       (clock),
      .reset       (reset),
      .lookup_addr (s1_addr_ff),
      .insert_en   (cam_insert),
      .result      (cam_res)
   );

   always_comb begin
      s1_idx = cam_res.hit_idx;
      priority if (s1_zero) begin
         s1_kind = KIND_ZERO;
      end else if (cam_res.hit) begin
         s1_kind = KIND_HIT;
      end else if (cam_res.free) begin
         s1_kind = KIND_INSERT;
         s1_idx  = cam_res.free_idx;
      end else begin
         s1_kind = KIND_FULL;
      end
   end

   // End of a new block, saturating at the top of the time range.
   assign block_sum    = {1'b0, s1_now_ff} + (TIME_W + 1)'(block_ff);
   assign s1_block_end = block_sum[TIME_W] ? '1 : block_sum[TIME_W-1:0];

   // Decision stage.
   kind_type          s2_kind_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic [TIME_W-1:0] s2_now_ff;
   logic [TIME_W-1:0] s2_block_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (st2_free) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move1) begin
         s2_kind_ff      <= s1_kind;
         s2_idx_ff       <= s1_idx;
         s2_now_ff       <= s1_now_ff;
         s2_block_end_ff <= s1_block_end;
      end
   end

   // Record table. The read is issued as the transaction enters the decision
   // stage; a write committed in that same cycle is picked up by the bypass.
   rec_type     ram_rdata;
   rec_type     cur_rec;
   rec_type     wr_rec;
   logic        wr_need;
   logic        ram_we;
   logic        byp_valid_ff;
   logic [IDX_W-1:0] byp_idx_ff;
   rec_type     byp_rec_ff;
   logic        s2_accepted;
   verdict_type s2_verdict;

   assign ram_we = move2 && wr_need;

   psrl_ram #(
      .WIDTH (REC_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_rec_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_idx_ff),
      .wr_data (wr_rec),
      .rd_en   (move1),
      .rd_addr (s1_idx),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_valid_ff <= 1'b0;
      end else if (ram_we) begin
         byp_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_we) begin
         byp_idx_ff <= s2_idx_ff;
         byp_rec_ff <= wr_rec;
      end
   end

   assign cur_rec = (byp_valid_ff && (byp_idx_ff == s2_idx_ff)) ? byp_rec_ff : ram_rdata;

   psrl_eval u_eval (
      .kind             (s2_kind_ff),
      .now_ms           (s2_now_ff),
      .block_end        (s2_block_end_ff),
      .rec              (cur_rec),
      .window_length_ms (window_ff),
      .max_per_window   (max_ff),
      .accepted         (s2_accepted),
      .verdict_code     (s2_verdict),
      .wr_en            (wr_need),
      .wr_rec           (wr_rec)
   );

   // Response register.
   logic        rsp_accepted_ff;
   verdict_type rsp_verdict_ff;
   logic        rsp_flag_expected;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         rsp_accepted_ff <= s2_accepted;
         rsp_verdict_ff  <= s2_verdict;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_verdict_ff, rsp_accepted_ff};

   // Only a plain accept and an untracked accept let the connection through.
   assign rsp_flag_expected = (rsp_verdict_ff == V_OK) || (rsp_verdict_ff == V_FULL);

   `PSRL_ASSERT_IMP(a_rsp_flag_matches_code, clock, reset, rsp_valid_ff, rsp_accepted_ff == rsp_flag_expected)
   `PSRL_ASSERT_NXT(a_decision_reaches_output, clock, reset, move2, rsp_valid_ff)
   `PSRL_ASSERT_IMP(a_ready_when_lookup_empty, clock, reset, !s1_valid_ff, req_tready)

endmodule

`default_nettype wire

>>> src/psrl_ram.sv
// ----------------------------------------------------------------------------
// psrl_ram
// Generic single-write, single-read RAM with registered, read-first output.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/psrl_cam.sv
// ----------------------------------------------------------------------------
// psrl_cam
// Fully associative address table with valid bits and lowest-free insertion.
// ----------------------------------------------------------------------------
`default_nettype none
`include "per_source_connection_rate_limiter_macros.svh"

module psrl_cam (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic [psrl_pkg::ADDR_W-1:0]     lookup_addr,
   input  wire logic                            insert_en,
   output psrl_pkg::cam_result_type             result
);
   import psrl_pkg::*;

   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   logic [ADDR_W-1:0]        addr_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] hit_vec;

   // Parallel compare, then lowest-index priority pick for hit and free slot.
   always_comb begin
      result = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (addr_ff[i] == lookup_addr);
      end
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            result.hit     = 1'b1;
            result.hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            result.free     = 1'b1;
            result.free_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (insert_en) begin
         valid_in[result.free_idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (insert_en) begin
         addr_ff[result.free_idx] <= lookup_addr;
      end
   end

   `PSRL_ASSERT_IMP(a_cam_single_hit, clock, reset, 1'b1, $onehot0(hit_vec))
   `PSRL_ASSERT_IMP(a_cam_insert_needs_slot, clock, reset, insert_en, !result.hit && result.free)
   `PSRL_ASSERT_NXT(a_cam_insert_sets_valid, clock, reset, insert_en, valid_ff[$past(result.free_idx)])

endmodule

`default_nettype wire

>>> src/psrl_eval.sv
// ----------------------------------------------------------------------------
// psrl_eval
// Decision stage: verdict and updated table record for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module psrl_eval (
   input  wire psrl_pkg::kind_type                kind,
   input  wire logic [psrl_pkg::TIME_W-1:0]       now_ms,
   input  wire logic [psrl_pkg::TIME_W-1:0]       block_end,
   input  wire psrl_pkg::rec_type                 rec,
   input  wire logic [psrl_pkg::WINDOW_W-1:0]     window_length_ms,
   input  wire logic [psrl_pkg::MAX_W-1:0]        max_per_window,
   output logic                                   accepted,
   output psrl_pkg::verdict_type                  verdict_code,
   output logic                                   wr_en,
   output psrl_pkg::rec_type                      wr_rec
);
   import psrl_pkg::*;

   logic [COUNT_W-1:0] count_inc;
   logic [TIME_W-1:0]  elapsed;

   assign count_inc = (rec.count != COUNT_MAX) ? rec.count + 1'b1 : rec.count;
   assign elapsed   = now_ms - rec.window_start;

   always_comb begin
      verdict_code = V_OK;
      wr_en        = 1'b0;
      wr_rec       = rec;
      unique case (kind)
         KIND_ZERO: begin
            verdict_code = V_ZERO;
         end
         KIND_FULL: begin
            verdict_code = V_FULL;
         end
         KIND_INSERT: begin
            wr_en               = 1'b1;
            wr_rec.window_start = now_ms;
            wr_rec.block_until  = '0;
            wr_rec.count        = COUNT_W'(1);
         end
         KIND_HIT: begin
            wr_en        = 1'b1;
            wr_rec.count = count_inc;
            if (rec.block_until > now_ms) begin
               verdict_code = V_BLOCKED;
            end else if (elapsed > TIME_W'(window_length_ms)) begin
               // Window ran out: sample the count and start a new window.
               wr_rec.window_start = now_ms;
               wr_rec.count        = '0;
               wr_rec.block_until  = '0;
               if (count_inc > max_per_window) begin
                  wr_rec.block_until = block_end;
                  verdict_code       = V_NEWBLOCK;
               end
            end
         end
         default: begin
            verdict_code = V_OK;
         end
      endcase
   end

   assign accepted = (verdict_code == V_OK) || (verdict_code == V_FULL);

endmodule

`default_nettype wire

>>> bench/rate_limit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rate_limit_checker
// Watches the request, response and register channels of the connection rate
// limiter, predicts each verdict from its own copy of the address table and
// compares every response transaction with the oldest predicted verdict.
// ----------------------------------------------------------------------------
module rate_limit_checker
   import psrl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output int                          outstanding,
   output int                          mismatches,
   output int                          compared,
   output int                          blocked_seen,
   output int                          full_seen
);

   typedef struct packed {
      logic        accepted;
      verdict_type code;
   } verdict_rec_type;

   verdict_rec_type verdict_q [$];

   logic               slot_used         [TABLE_ENTRIES];
   logic [ADDR_W-1:0]  slot_addr         [TABLE_ENTRIES];
   logic [TIME_W-1:0]  slot_window_start [TABLE_ENTRIES];
   logic [TIME_W-1:0]  slot_block_until  [TABLE_ENTRIES];
   logic [COUNT_W-1:0] slot_hits         [TABLE_ENTRIES];

   logic [WINDOW_W-1:0] win_len;
   logic [MAX_W-1:0]    hit_limit;
   logic [BLOCK_W-1:0]  ban_len;

   int failures;
   int n_compared;
   int n_blocked;
   int n_full;

   // Decides one request and updates the table copy the same way the block
   // is meant to.
   function automatic verdict_rec_type judge_request(input logic [ADDR_W-1:0] addr,
                                                     input logic [TIME_W-1:0] stamp);
      verdict_rec_type    r;
      int                 i;
      int                 hit_at;
      int                 free_at;
      logic [TIME_W-1:0]  age;
      logic [TIME_W:0]    ban_end;
      logic [COUNT_W-1:0] sample;
      hit_at     = -1;
      free_at    = -1;
      r.accepted = 1'b1;
      r.code     = V_OK;
      if (addr == '0) begin
         r.accepted = 1'b0;
         r.code     = V_ZERO;
      end else begin
         for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
               if (hit_at < 0 && slot_addr[i] == addr) hit_at = i;
            end else if (free_at < 0) begin
               free_at = i;
            end
         end
         if (hit_at < 0) begin
            if (free_at < 0) begin
               r.code = V_FULL;
            end else begin
               slot_used[free_at]         = 1'b1;
               slot_addr[free_at]         = addr;
               slot_window_start[free_at] = stamp;
               slot_block_until[free_at]  = '0;
               slot_hits[free_at]         = COUNT_W'(1);
            end
         end else begin
            if (slot_hits[hit_at] != COUNT_MAX) slot_hits[hit_at] = slot_hits[hit_at] + 1'b1;
            age = stamp - slot_window_start[hit_at];
            if (slot_block_until[hit_at] > stamp) begin
               r.accepted = 1'b0;
               r.code     = V_BLOCKED;
            end else if (age > TIME_W'(win_len)) begin
               sample                    = slot_hits[hit_at];
               slot_window_start[hit_at] = stamp;
               slot_hits[hit_at]         = '0;
               slot_block_until[hit_at]  = '0;
               if (sample > hit_limit) begin
                  // The block end saturates at the top of the time range.
                  ban_end = {1'b0, stamp} + (TIME_W+1)'(ban_len);
                  slot_block_until[hit_at] = ban_end[TIME_W] ? '1 : ban_end[TIME_W-1:0];
                  r.accepted = 1'b0;
                  r.code     = V_NEWBLOCK;
               end
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin : track
      verdict_rec_type want;
      int              i;
      if (reset) begin
         for (i = 0; i < TABLE_ENTRIES; i++) begin
            slot_used[i]         = 1'b0;
            slot_addr[i]         = '0;
            slot_window_start[i] = '0;
            slot_block_until[i]  = '0;
            slot_hits[i]         = '0;
         end
         win_len    = WINDOW_RESET;
         hit_limit  = MAX_RESET;
         ban_len    = BLOCK_RESET;
         verdict_q.delete();
         failures   = 0;
         n_compared = 0;
         n_blocked  = 0;
         n_full     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LENGTH:  win_len   = csr_data[WINDOW_W-1:0];
               CSR_MAX_PER_WINDOW: hit_limit = csr_data[MAX_W-1:0];
               CSR_BLOCK_LENGTH:   ban_len   = csr_data[BLOCK_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            verdict_q.push_back(judge_request(req_tdata[ADDR_W-1:0],
                                              req_tdata[ADDR_W +: TIME_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("%0t: response with no request pending: tdata=%h",
                           $realtime, rsp_tdata);
            end else begin
               want = verdict_q.pop_front();
               n_compared++;
               if (want.code == V_BLOCKED || want.code == V_NEWBLOCK) n_blocked++;
               if (want.code == V_FULL) n_full++;
               if (rsp_tdata[0] !== want.accepted || rsp_tdata[3:1] !== want.code) begin
                  failures++;
                  if (failures <= 10)
                     $display("%0t: response %0d: expected accepted=%0b verdict=%0d, ",
                              $realtime, n_compared, want.accepted, want.code,
                              "got accepted=%0b verdict=%0d",
                              rsp_tdata[0], rsp_tdata[3:1]);
               end
            end
         end
      end
      outstanding  <= verdict_q.size();
      mismatches   <= failures;
      compared     <= n_compared;
      blocked_seen <= n_blocked;
      full_seen    <= n_full;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source connection rate limiter. Drives
// directed and random connection requests under several register settings,
// with random idling on both streams, and lets a checker compare every
// response transaction against its own prediction.
// ----------------------------------------------------------------------------
module tb;
   import psrl_pkg::*;

   // The register map leaves index 3 unused; a write there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   // Hang guard, set well above the slowest legal run: about 1300 requests,
   // each paying a long sender gap, a long receiver stall and the pipeline.
   localparam int RUN_LIMIT_NS = 5_000_000;

   localparam int PHASE_ITEMS   = 200;
   localparam int PHASES        = 6;
   localparam int POOL_SIZE     = 72;   // more sources than table entries
   localparam int HOT_SIZE      = 4;    // a few noisy sources that get blocked
   localparam int BURST_HITS    = 40;

   localparam logic [ADDR_W-1:0] BURST_SOURCE = 32'h5A5A_0F0F;
   localparam logic [TIME_W-1:0] BURST_TIME   = 48'd20000;
   localparam logic [TIME_W-1:0] TIME_TOP     = '1;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // [31:0] source_address, [79:32] now_ms
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] accepted, [3:1] verdict_code, [7:4] zero
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int outstanding;
   int mismatches;
   int compared;
   int blocked_seen;
   int full_seen;

   int                requests_sent = 0;
   int                settings_used = 0;
   logic [TIME_W-1:0] stamp_ms      = '0;
   logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

   always #2 clock = ~clock;

   per_source_connection_rate_limiter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   rate_limit_checker verdict_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .outstanding  (outstanding),
      .mismatches   (mismatches),
      .compared     (compared),
      .blocked_seen (blocked_seen),
      .full_seen    (full_seen)
   );

   // Idle gap length: mostly none, often short, now and then a long one.
   function automatic int pick_gap();
      int roll;
      int gap;
      roll = $urandom_range(0, 99);
      if (roll < 60) gap = 0;
      else if (roll < 92) gap = $urandom_range(1, 3);
      else gap = $urandom_range(8, 40);
      return gap;
   endfunction

   // Offers one request and returns in the time step of the edge that took it.
   // With paced set, a random idle gap comes first; otherwise tvalid stays
   // high from the previous transaction.
   task automatic present_request(input logic [ADDR_W-1:0] addr,
                                  input logic [TIME_W-1:0] stamp,
                                  input bit paced);
      int pause;
      pause = paced ? pick_gap() : 0;
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {stamp, addr};
      do @(posedge clock); while (!req_tready);
      requests_sent++;
   endtask

   // Stops offering and waits until every predicted verdict has come back.
   // Every request produces a response, so nothing is still in flight then.
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // One register write transaction; csr_valid is handled by the caller so
   // that back-to-back writes keep it high.
   task automatic csr_beat(input logic [CSR_INDEX_W-1:0] index,
                           input logic [CSR_DATA_W-1:0] value);
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Writes all three registers while the block is idle. Optionally also
   // writes the unused index, which must leave the settings alone.
   task automatic configure(input logic [WINDOW_W-1:0] win,
                            input logic [MAX_W-1:0] lim,
                            input logic [BLOCK_W-1:0] ban,
                            input bit poke_unmapped);
      drain();
      csr_valid <= 1'b1;
      csr_beat(CSR_WINDOW_LENGTH, CSR_DATA_W'(win));
      csr_beat(CSR_MAX_PER_WINDOW, CSR_DATA_W'(lim));
      csr_beat(CSR_BLOCK_LENGTH, CSR_DATA_W'(ban));
      if (poke_unmapped) csr_beat(CSR_UNMAPPED, CSR_DATA_W'($urandom()));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Response side. Ready follows random gaps, with occasional stretches of
   // constant ready. Every 20000 responses, starting at the 700th, it also
   // holds ready low for a long stretch while the sender keeps offering, so
   // the pipeline fills up and req_tready has to drop.
   initial begin : response_side
      int taken;
      int idle_left;
      int hold_left;
      int steady_left;
      taken       = 0;
      idle_left   = 0;
      hold_left   = 0;
      steady_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            taken++;
            if (taken % 20000 == 700) hold_left = 240;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (steady_left > 0) begin
            steady_left--;
            rsp_tready <= 1'b1;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0) steady_left = $urandom_range(50, 400);
            else idle_left = pick_gap();
         end
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      int                p;
      int                n;
      int                i;
      int                roll;
      logic [ADDR_W-1:0] pick;
      logic [ADDR_W-1:0] fresh;

      // Source addresses for the random part. The first HOT_SIZE of them get
      // the most traffic each, so that their counts climb past the limit.
      for (i = 0; i < POOL_SIZE; i++) begin
         fresh = $urandom();
         addr_pool[i] = (fresh == '0) ? 32'h1 : fresh;
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed requests under the reset settings (1000 ms window, limit 10,
      // 10000 ms block). A zero address is rejected at both time extremes, a
      // new source is taken in, a request exactly at the window edge stays in
      // the window and one past it restarts the window without blocking.
      present_request('0, '0, 1'b1);
      present_request('0, TIME_TOP, 1'b1);
      present_request(32'hFFFF_FFFF, 48'd0, 1'b1);
      present_request(32'hFFFF_FFFF, 48'd1000, 1'b1);
      present_request(32'hFFFF_FFFF, 48'd1001, 1'b1);
      present_request(32'h0000_0001, 48'd5000, 1'b1);

      // Tight window and limit with the longest block. Source 2 gets blocked
      // and then hits the block. Source 3 is blocked near the top of the time
      // range, where the block end saturates, and stays blocked when time
      // jumps back to zero. Source 1 sees time run backwards, so its window
      // age wraps and a fresh block starts.
      configure(16'd10, 16'd1, 24'hFF_FFFF, 1'b0);
      present_request(32'h0000_0002, 48'd100, 1'b1);
      present_request(32'h0000_0002, 48'd105, 1'b1);
      present_request(32'h0000_0002, 48'd120, 1'b1);
      present_request(32'h0000_0002, 48'd200, 1'b1);
      present_request(32'h0000_0003, TIME_TOP - 48'd20, 1'b1);
      present_request(32'h0000_0003, TIME_TOP - 48'd15, 1'b1);
      present_request(32'h0000_0003, TIME_TOP, 1'b1);
      present_request(32'h0000_0003, 48'd0, 1'b1);
      present_request(32'h0000_0001, 48'd3, 1'b1);
      present_request(32'h8000_0000, 48'd7, 1'b1);
      present_request(32'h0000_0001, 48'd8, 1'b1);

      // Back-to-back burst: with the widest window and time standing still,
      // one source sends a run of requests at full rate, so each decision
      // depends on the record written by the one just before it. The first
      // request past the window samples a count above the limit and blocks.
      configure(16'hFFFF, 16'd30, 24'd3, 1'b0);
      present_request(BURST_SOURCE, BURST_TIME, 1'b1);
      repeat (BURST_HITS) present_request(BURST_SOURCE, BURST_TIME, 1'b0);
      present_request(BURST_SOURCE, BURST_TIME + 48'd65536, 1'b1);
      present_request(BURST_SOURCE, BURST_TIME + 48'd65537, 1'b1);
      present_request(BURST_SOURCE, BURST_TIME + 48'd65539, 1'b1);

      // Random part, one register setting per phase: the reset values (plus a
      // write to the unused index), all-zero settings, all-ones settings, a
      // tight setting and two random ones.
      stamp_ms = 48'd100000;
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: configure(WINDOW_RESET, MAX_RESET, BLOCK_RESET, 1'b1);
            1: configure('0, '0, '0, 1'b0);
            2: configure('1, '1, '1, 1'b0);
            3: configure(16'd50, 16'd2, 24'd200, 1'b0);
            default: configure(WINDOW_W'($urandom_range(0, 2000)),
                               MAX_W'($urandom_range(0, 6)),
                               BLOCK_W'($urandom_range(0, 5000)), 1'b0);
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            // Fresh random sources only start once most of the pool has been
            // seen; by then the table is full and they go through untracked.
            roll = $urandom_range(0, 99);
            if (roll < 4) pick = '0;
            else if (roll < 12 && p >= 2) pick = $urandom();
            else if (roll < 55) pick = addr_pool[$urandom_range(0, HOT_SIZE - 1)];
            else pick = addr_pool[$urandom_range(0, POOL_SIZE - 1)];

            // Time mostly creeps forward; rarely it leaps to a random point
            // (possibly backwards) or steps back a little.
            roll = $urandom_range(0, 199);
            if (roll < 2) stamp_ms = TIME_W'({$urandom(), $urandom()});
            else if (roll < 3) stamp_ms = stamp_ms - TIME_W'($urandom_range(1, 100));
            else if (roll < 130) stamp_ms = stamp_ms + TIME_W'($urandom_range(0, 3));
            else if (roll < 180) stamp_ms = stamp_ms + TIME_W'($urandom_range(0, 80));
            else stamp_ms = stamp_ms + TIME_W'($urandom_range(0, 3000));

            present_request(pick, stamp_ms, 1'b1);
         end
      end

      drain();
      repeat (8) @(posedge clock);

      $display("Covered %0d requests under %0d register settings, %0d responses compared.",
               requests_sent, settings_used, compared);
      $display("Rejections for blocked sources: %0d; untracked accepts with a full table: %0d.",
               blocked_seen, full_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+src
src/psrl_pkg.sv
src/psrl_ram.sv
src/psrl_cam.sv
src/psrl_eval.sv
src/per_source_connection_rate_limiter.sv
bench/rate_limit_checker.sv
bench/tb.sv
